### hdl/bpt_pkg.sv
// Shared constants and types for the barycentric point-in-triangle test.
`default_nettype none
package bpt_pkg;

    // Default widths of one coordinate and of one output weight.
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int WEIGHT_WIDTH_DEF = 24;

    // Fraction bits of the Q8.16 weights.
    localparam int FRAC_BITS = 16;

    // Flags that travel with the magnitudes into the divider.
    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic in_tri;
        logic deg;
    } bpt_flags_t;

endpackage
`default_nettype wire

### hdl/bpt_query_if.sv
// Channel interfaces: query word in, result word out.
`default_nettype none
interface bpt_query_if import bpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] corner_a_x;
    logic signed [COORD_WIDTH-1:0] corner_a_y;
    logic signed [COORD_WIDTH-1:0] corner_a_z;
    logic signed [COORD_WIDTH-1:0] corner_b_x;
    logic signed [COORD_WIDTH-1:0] corner_b_y;
    logic signed [COORD_WIDTH-1:0] corner_b_z;
    logic signed [COORD_WIDTH-1:0] corner_c_x;
    logic signed [COORD_WIDTH-1:0] corner_c_y;
    logic signed [COORD_WIDTH-1:0] corner_c_z;

    modport source (
        output valid, point_x, point_y, point_z, corner_a_x, corner_a_y, corner_a_z,
               corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, corner_a_x, corner_a_y, corner_a_z,
               corner_b_x, corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
        output ready
    );
endinterface

interface bpt_result_if import bpt_pkg::*; #(
    parameter int WEIGHT_WIDTH = WEIGHT_WIDTH_DEF
) ();
    logic valid;
    logic ready;
    logic signed [WEIGHT_WIDTH-1:0] weight_u;
    logic signed [WEIGHT_WIDTH-1:0] weight_v;
    logic inside_res;
    logic degenerate;

    modport source (output valid, weight_u, weight_v, inside_res, degenerate, input ready);
    modport sink   (input valid, weight_u, weight_v, inside_res, degenerate, output ready);
endinterface
`default_nettype wire

### hdl/bpt_front.sv
// Front pipeline: edge vectors, coordinate products and the five dot products.
`default_nettype none
module bpt_front import bpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bpt_query_if.sink query,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [2*COORD_WIDTH+3:0] d00,
    output logic signed [2*COORD_WIDTH+3:0] d01,
    output logic signed [2*COORD_WIDTH+3:0] d02,
    output logic signed [2*COORD_WIDTH+3:0] d11,
    output logic signed [2*COORD_WIDTH+3:0] d12
);
    localparam int EW = COORD_WIDTH + 1;
    localparam int PW = 2 * EW;
    localparam int DW = PW + 2;
    localparam int NS = 3;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   go;
    logic [NS-1:0] vin;

    logic signed [EW-1:0] e0_reg [3];
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] e0_next [3];
    logic signed [EW-1:0] e1_next [3];
    logic signed [EW-1:0] e2_next [3];
    logic signed [PW-1:0] pr_reg [5][3];
    logic signed [DW-1:0] dot_reg [5];
    logic signed [COORD_WIDTH-1:0] pc [3];
    logic signed [COORD_WIDTH-1:0] ac [3];
    logic signed [COORD_WIDTH-1:0] bc [3];
    logic signed [COORD_WIDTH-1:0] cc [3];

    // A stage moves when it is empty or its successor moves.
    always_comb
    begin
        go[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            go[k] = !vld_reg[k] || go[k+1];
        end
        vin = {vld_reg[NS-2:0], query.valid};
    end

    assign query.ready = go[0];
    assign out_valid   = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (go[k])
                begin
                    vld_reg[k] <= vin[k];
                end
            end
        end
    end

    // Edge vectors from corner A, one bit wider than a coordinate.
    always_comb
    begin
        pc[0] = query.point_x;    pc[1] = query.point_y;    pc[2] = query.point_z;
        ac[0] = query.corner_a_x; ac[1] = query.corner_a_y; ac[2] = query.corner_a_z;
        bc[0] = query.corner_b_x; bc[1] = query.corner_b_y; bc[2] = query.corner_b_z;
        cc[0] = query.corner_c_x; cc[1] = query.corner_c_y; cc[2] = query.corner_c_z;
        for (int i = 0; i < 3; i++)
        begin
            e0_next[i] = {cc[i][COORD_WIDTH-1], cc[i]} - {ac[i][COORD_WIDTH-1], ac[i]};
            e1_next[i] = {bc[i][COORD_WIDTH-1], bc[i]} - {ac[i][COORD_WIDTH-1], ac[i]};
            e2_next[i] = {pc[i][COORD_WIDTH-1], pc[i]} - {ac[i][COORD_WIDTH-1], ac[i]};
        end
    end

    // Stage registers: edges, then products, then dot sums.
    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            e0_reg <= e0_next;
            e1_reg <= e1_next;
            e2_reg <= e2_next;
        end
        if (go[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pr_reg[0][i] <= PW'(e0_reg[i]) * PW'(e0_reg[i]);
                pr_reg[1][i] <= PW'(e0_reg[i]) * PW'(e1_reg[i]);
                pr_reg[2][i] <= PW'(e0_reg[i]) * PW'(e2_reg[i]);
                pr_reg[3][i] <= PW'(e1_reg[i]) * PW'(e1_reg[i]);
                pr_reg[4][i] <= PW'(e1_reg[i]) * PW'(e2_reg[i]);
            end
        end
        if (go[2])
        begin
            for (int j = 0; j < 5; j++)
            begin
                dot_reg[j] <= DW'(pr_reg[j][0]) + DW'(pr_reg[j][1]) + DW'(pr_reg[j][2]);
            end
        end
    end

    assign d00 = dot_reg[0];
    assign d01 = dot_reg[1];
    assign d02 = dot_reg[2];
    assign d11 = dot_reg[3];
    assign d12 = dot_reg[4];
endmodule
`default_nettype wire

### hdl/bpt_solve.sv
// Middle pipeline: determinant and numerators, sign fix-up and inside test.
`default_nettype none
module bpt_solve import bpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [2*COORD_WIDTH+3:0] d00,
    input  logic signed [2*COORD_WIDTH+3:0] d01,
    input  logic signed [2*COORD_WIDTH+3:0] d02,
    input  logic signed [2*COORD_WIDTH+3:0] d11,
    input  logic signed [2*COORD_WIDTH+3:0] d12,
    output logic out_valid,
    input  logic out_ready,
    output logic [4*COORD_WIDTH+8:0] mag_u,
    output logic [4*COORD_WIDTH+8:0] mag_v,
    output logic [4*COORD_WIDTH+8:0] den,
    output bpt_flags_t flags
);
    localparam int DW  = 2 * COORD_WIDTH + 4;
    localparam int LW  = DW / 2;
    localparam int PPW = 2 * LW + 2;
    localparam int QW  = 2 * DW;
    localparam int NW  = QW + 1;
    localparam int NS  = 5;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   go;
    logic [NS-1:0] vin;

    logic signed [DW-1:0]  opa [6];
    logic signed [DW-1:0]  opb [6];
    logic signed [LW:0]    ah [6];
    logic signed [LW:0]    al [6];
    logic signed [LW:0]    bh [6];
    logic signed [LW:0]    bl [6];
    logic signed [PPW-1:0] hh_reg [6];
    logic signed [PPW-1:0] hl_reg [6];
    logic signed [PPW-1:0] lh_reg [6];
    logic signed [PPW-1:0] ll_reg [6];
    logic signed [QW-1:0]  prod_reg [6];
    logic signed [NW-1:0]  det_reg;
    logic signed [NW-1:0]  nu_reg;
    logic signed [NW-1:0]  nv_reg;
    logic signed [NW-1:0]  detn_reg;
    logic signed [NW-1:0]  nun_reg;
    logic signed [NW-1:0]  nvn_reg;
    logic                  deg3_reg;
    logic signed [NW+1:0]  slack;
    logic [NW-1:0]         magu_reg;
    logic [NW-1:0]         magv_reg;
    logic [NW-1:0]         den_reg;
    bpt_flags_t            flags_reg;

    // Handshake ripple through the stages.
    always_comb
    begin
        go[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            go[k] = !vld_reg[k] || go[k+1];
        end
        vin = {vld_reg[NS-2:0], in_valid};
    end

    assign in_ready  = go[0];
    assign out_valid = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (go[k])
                begin
                    vld_reg[k] <= vin[k];
                end
            end
        end
    end

    // Operands of the six wide products, split into signed high and unsigned low halves.
    always_comb
    begin
        opa[0] = d00; opb[0] = d11;
        opa[1] = d01; opb[1] = d01;
        opa[2] = d11; opb[2] = d02;
        opa[3] = d01; opb[3] = d12;
        opa[4] = d00; opb[4] = d12;
        opa[5] = d01; opb[5] = d02;
        for (int j = 0; j < 6; j++)
        begin
            ah[j] = {opa[j][DW-1], opa[j][DW-1:LW]};
            al[j] = {1'b0, opa[j][LW-1:0]};
            bh[j] = {opb[j][DW-1], opb[j][DW-1:LW]};
            bl[j] = {1'b0, opb[j][LW-1:0]};
        end
    end

    // Inside test on the sign-corrected values.
    assign slack = (NW+2)'(detn_reg) - (NW+2)'(nun_reg) - (NW+2)'(nvn_reg);

    always_ff @(posedge clk)
    begin
        // Partial products.
        if (go[0])
        begin
            for (int j = 0; j < 6; j++)
            begin
                hh_reg[j] <= PPW'(ah[j]) * PPW'(bh[j]);
                hl_reg[j] <= PPW'(ah[j]) * PPW'(bl[j]);
                lh_reg[j] <= PPW'(al[j]) * PPW'(bh[j]);
                ll_reg[j] <= PPW'(al[j]) * PPW'(bl[j]);
            end
        end
        // Recombine the partials into full products.
        if (go[1])
        begin
            for (int j = 0; j < 6; j++)
            begin
                prod_reg[j] <= (QW'(hh_reg[j]) << (2 * LW))
                             + ((QW'(hl_reg[j]) + QW'(lh_reg[j])) << LW)
                             + QW'(ll_reg[j]);
            end
        end
        // Determinant and the two numerators.
        if (go[2])
        begin
            det_reg <= NW'(prod_reg[0]) - NW'(prod_reg[1]);
            nu_reg  <= NW'(prod_reg[2]) - NW'(prod_reg[3]);
            nv_reg  <= NW'(prod_reg[4]) - NW'(prod_reg[5]);
        end
        // Make the determinant non-negative.
        if (go[3])
        begin
            deg3_reg <= (det_reg == '0);
            if (det_reg[NW-1])
            begin
                detn_reg <= -det_reg;
                nun_reg  <= -nu_reg;
                nvn_reg  <= -nv_reg;
            end
            else
            begin
                detn_reg <= det_reg;
                nun_reg  <= nu_reg;
                nvn_reg  <= nv_reg;
            end
        end
        // Magnitudes, signs and the inside decision.
        if (go[4])
        begin
            magu_reg         <= nun_reg[NW-1] ? NW'(-nun_reg) : NW'(nun_reg);
            magv_reg         <= nvn_reg[NW-1] ? NW'(-nvn_reg) : NW'(nvn_reg);
            den_reg          <= NW'(detn_reg);
            flags_reg.neg_u  <= nun_reg[NW-1];
            flags_reg.neg_v  <= nvn_reg[NW-1];
            flags_reg.in_tri <= !nun_reg[NW-1] && !nvn_reg[NW-1] && !slack[NW+1]
                                && !deg3_reg;
            flags_reg.deg    <= deg3_reg;
        end
    end

    assign mag_u = magu_reg;
    assign mag_v = magv_reg;
    assign den   = den_reg;
    assign flags = flags_reg;
endmodule
`default_nettype wire

### hdl/bpt_div.sv
// Divider pipeline: one quotient bit per stage for both weights, then saturation.
`default_nettype none
module bpt_div import bpt_pkg::*; #(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int WEIGHT_WIDTH = WEIGHT_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [4*COORD_WIDTH+8:0] mag_u,
    input  logic [4*COORD_WIDTH+8:0] mag_v,
    input  logic [4*COORD_WIDTH+8:0] den,
    input  bpt_flags_t flags,
    bpt_result_if.source answer
);
    localparam int NW = 4 * COORD_WIDTH + 9;
    localparam int WW = WEIGHT_WIDTH;
    localparam int RW = NW + FRAC_BITS + WW;
    localparam int NS = WW + 2;
    localparam logic [WW-1:0] LIM = {1'b1, {(WW-1){1'b0}}};
    localparam logic [WW-1:0] MAXW = {1'b0, {(WW-1){1'b1}}};

    logic [NS-1:0] vld_reg;
    logic [NS:0]   go;
    logic [NS-1:0] vin;

    logic [RW-1:0] remu_reg [WW+1];
    logic [RW-1:0] remv_reg [WW+1];
    logic [WW-1:0] qu_reg [WW+1];
    logic [WW-1:0] qv_reg [WW+1];
    logic [NW-1:0] den_reg [WW+1];
    logic          ovfu_reg [WW+1];
    logic          ovfv_reg [WW+1];
    bpt_flags_t    flg_reg [WW+1];

    logic [RW-1:0] numu;
    logic [RW-1:0] numv;
    logic [RW-1:0] dtop;
    logic [WW-1:0] wu_next;
    logic [WW-1:0] wv_next;
    logic [WW-1:0] wu_reg;
    logic [WW-1:0] wv_reg;
    logic          in_tri_reg;
    logic          deg_reg;

    // Handshake ripple through the stages.
    always_comb
    begin
        go[NS] = answer.ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            go[k] = !vld_reg[k] || go[k+1];
        end
        vin = {vld_reg[NS-2:0], in_valid};
    end

    assign in_ready = go[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (go[k])
                begin
                    vld_reg[k] <= vin[k];
                end
            end
        end
    end

    // Scaled numerators and the overflow check against den * 2^WW.
    assign numu = RW'(mag_u) << FRAC_BITS;
    assign numv = RW'(mag_v) << FRAC_BITS;
    assign dtop = RW'(den) << WW;

    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            remu_reg[0] <= numu;
            remv_reg[0] <= numv;
            qu_reg[0]   <= '0;
            qv_reg[0]   <= '0;
            den_reg[0]  <= den;
            ovfu_reg[0] <= (numu >= dtop);
            ovfv_reg[0] <= (numv >= dtop);
            flg_reg[0]  <= flags;
        end
    end

    // Restoring division, most significant quotient bit first.
    for (genvar k = 1; k <= WW; k++)
    begin : g_step
        localparam int B = WW - k;
        logic [RW-1:0] dsh;
        assign dsh = RW'(den_reg[k-1]) << B;

        always_ff @(posedge clk)
        begin
            if (go[k])
            begin
                den_reg[k]  <= den_reg[k-1];
                ovfu_reg[k] <= ovfu_reg[k-1];
                ovfv_reg[k] <= ovfv_reg[k-1];
                flg_reg[k]  <= flg_reg[k-1];
                if (remu_reg[k-1] >= dsh)
                begin
                    remu_reg[k]  <= remu_reg[k-1] - dsh;
                    qu_reg[k]    <= qu_reg[k-1] | (WW'(1) << B);
                end
                else
                begin
                    remu_reg[k]  <= remu_reg[k-1];
                    qu_reg[k]    <= qu_reg[k-1];
                end
                if (remv_reg[k-1] >= dsh)
                begin
                    remv_reg[k]  <= remv_reg[k-1] - dsh;
                    qv_reg[k]    <= qv_reg[k-1] | (WW'(1) << B);
                end
                else
                begin
                    remv_reg[k]  <= remv_reg[k-1];
                    qv_reg[k]    <= qv_reg[k-1];
                end
            end
        end
    end

    // Sign, saturation and degenerate zeroing of the truncated quotients.
    always_comb
    begin
        if (flg_reg[WW].deg)
        begin
            wu_next = '0;
        end
        else if (!flg_reg[WW].neg_u)
        begin
            wu_next = (ovfu_reg[WW] || qu_reg[WW][WW-1]) ? MAXW : qu_reg[WW];
        end
        else
        begin
            wu_next = (ovfu_reg[WW] || (qu_reg[WW] > LIM)) ? LIM : -qu_reg[WW];
        end
        if (flg_reg[WW].deg)
        begin
            wv_next = '0;
        end
        else if (!flg_reg[WW].neg_v)
        begin
            wv_next = (ovfv_reg[WW] || qv_reg[WW][WW-1]) ? MAXW : qv_reg[WW];
        end
        else
        begin
            wv_next = (ovfv_reg[WW] || (qv_reg[WW] > LIM)) ? LIM : -qv_reg[WW];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (go[NS-1])
        begin
            wu_reg     <= wu_next;
            wv_reg     <= wv_next;
            in_tri_reg <= flg_reg[WW].in_tri;
            deg_reg    <= flg_reg[WW].deg;
        end
    end

    assign answer.valid      = vld_reg[NS-1];
    assign answer.weight_u   = wu_reg;
    assign answer.weight_v   = wv_reg;
    assign answer.inside_res = in_tri_reg;
    assign answer.degenerate = deg_reg;
endmodule
`default_nettype wire

### hdl/barycentric_point_in_triangle_top.sv
// Throughput: one query word per cycle while the result side keeps ready high;
// the depth is that of the front, solve and divider pipelines together.
// Each stage stalls only when full and blocked, so bubbles close up under back-pressure.
// Reset (rst_n, asynchronous, active low) empties the pipeline; no data is cleared.
`default_nettype none
module barycentric_point_in_triangle_top import bpt_pkg::*; #(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int WEIGHT_WIDTH = WEIGHT_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    bpt_query_if.sink query,
    bpt_result_if.source answer
);
    localparam int DW = 2 * COORD_WIDTH + 4;
    localparam int NW = 4 * COORD_WIDTH + 9;

    logic              f_valid;
    logic              f_ready;
    logic signed [DW-1:0] d00;
    logic signed [DW-1:0] d01;
    logic signed [DW-1:0] d02;
    logic signed [DW-1:0] d11;
    logic signed [DW-1:0] d12;
    logic              s_valid;
    logic              s_ready;
    logic [NW-1:0]     mag_u;
    logic [NW-1:0]     mag_v;
    logic [NW-1:0]     den;
    bpt_flags_t        flags;

    // Edges and dot products.
    bpt_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n), .query(query),
        .out_valid(f_valid), .out_ready(f_ready),
        .d00(d00), .d01(d01), .d02(d02), .d11(d11), .d12(d12)
    );

    // Determinant, numerators and inside test.
    bpt_solve #(.COORD_WIDTH(COORD_WIDTH)) u_solve (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready),
        .d00(d00), .d01(d01), .d02(d02), .d11(d11), .d12(d12),
        .out_valid(s_valid), .out_ready(s_ready),
        .mag_u(mag_u), .mag_v(mag_v), .den(den), .flags(flags)
    );

    // Weight division and saturation.
    bpt_div #(.COORD_WIDTH(COORD_WIDTH), .WEIGHT_WIDTH(WEIGHT_WIDTH)) u_div (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_valid), .in_ready(s_ready),
        .mag_u(mag_u), .mag_v(mag_v), .den(den), .flags(flags),
        .answer(answer)
    );
endmodule
`default_nettype wire
